### src/ordered_timer_queue_core_assert.svh
// Assertion macros for the ordered timer queue core.
// Included by ordered_timer_queue_core.sv; expects clk and arst_n in scope.
`ifndef ORDERED_TIMER_QUEUE_CORE_ASSERT_SVH
`define ORDERED_TIMER_QUEUE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define OTQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ordered_timer_queue_core: assertion failed");
// next-cycle implication
`define OTQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ordered_timer_queue_core: assertion failed");
`else
`define OTQ_ASSERT_NOW(label, ante, cons)
`define OTQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/otq_pkg.sv
// Shared types and constants for the ordered timer queue.
// No dependencies; used by ordered_timer_queue_core.
package otq_pkg;

	localparam int unsigned DUE_W = 48;
	localparam int unsigned ID_W  = 16;
	localparam int unsigned PER_W = 32;
	localparam int unsigned MIN_W = 16;

	localparam logic [MIN_W-1:0] MIN_ARM_RESET = 16'd100;

	// request codes
	localparam logic REQ_ADD    = 1'b0;
	localparam logic REQ_EXPIRE = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_ADD_OK   = 2'd0;
	localparam logic [1:0] KIND_FIRED    = 2'd1;
	localparam logic [1:0] KIND_EXP_DONE = 2'd2;
	localparam logic [1:0] KIND_FULL     = 2'd3;

	typedef struct packed {
		logic [DUE_W-1:0] due;
		logic [ID_W-1:0]  id;
		logic [PER_W-1:0] period;
	} entry_t;

	// fired repeating timer waiting to go back in
	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [PER_W-1:0] period;
	} refire_t;

endpackage

### src/ordered_timer_queue_core.sv
// Ordered timer queue core: sorted timer table with earliest-deadline re-arm; needs otq_pkg.
// A full add is refused with a single result word; an add walks the table from the tail;
// an expire drains due timers from the head, then re-inserts each fired repeating timer.
// Throughput: one request at a time, busy high while it runs (never for a refused add); one
// result word per cycle at most (single table port, shared comparator); the receiver never stalls.
// Reset (arst_n low, async): queue empty, min_arm_delay 100, table undefined.
`include "ordered_timer_queue_core_assert.svh"

module ordered_timer_queue_core #(
	parameter int unsigned MAX_TIMERS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request
	input  logic                         start,
	output logic                         busy,
	input  logic                         req_type,
	input  logic [otq_pkg::DUE_W-1:0]    now_time,
	input  logic [otq_pkg::ID_W-1:0]     timer_id,
	input  logic [otq_pkg::DUE_W-1:0]    due_time,
	input  logic [otq_pkg::PER_W-1:0]    repeat_period,
	// configuration
	input  logic                         min_arm_delay_we,
	input  logic [otq_pkg::MIN_W-1:0]    min_arm_delay,
	// results
	output logic                         result_valid,
	output logic [1:0]                   result_kind,
	output logic [otq_pkg::ID_W-1:0]     fired_id,
	output logic                         arm_valid,
	output logic [otq_pkg::DUE_W-1:0]    arm_delay,
	output logic                         last_result
);

	localparam int unsigned IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_TIMERS + 1);
	localparam int unsigned SUM_W = CNT_W + 1;
	localparam int unsigned KEY_W = otq_pkg::DUE_W + otq_pkg::ID_W;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TIMERS - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TIMERS);

	// sequencer
	localparam logic [2:0] ST_IDLE   = 3'd0; // waiting for a request
	localparam logic [2:0] ST_A_HEAD = 3'd1; // head read back, decide re-arm
	localparam logic [2:0] ST_INS    = 3'd2; // insertion walk, tail towards head
	localparam logic [2:0] ST_E_CHK  = 3'd3; // drain due timers from the head
	localparam logic [2:0] ST_R_LOAD = 3'd4; // fetch next repeating timer
	localparam logic [2:0] ST_E_RD   = 3'd5; // read new head
	localparam logic [2:0] ST_E_FIN  = 3'd6; // expire-done word

	logic [2:0]                  state_q;
	logic [IDX_W-1:0]            head_q;
	logic [CNT_W-1:0]            count_q;
	logic [otq_pkg::MIN_W-1:0]   min_delay_q;
	logic [otq_pkg::DUE_W-1:0]   now_q;
	logic [otq_pkg::DUE_W-1:0]   new_due_q;
	logic [otq_pkg::ID_W-1:0]    new_id_q;
	logic [otq_pkg::PER_W-1:0]   new_per_q;
	logic                        refill_q;   // insertion belongs to an expire
	logic                        earliest_q;
	logic [IDX_W-1:0]            walk_ptr_q; // physical slot being filled
	logic [CNT_W-1:0]            walk_n_q;   // its logical position
	logic [CNT_W-1:0]            fb_n_q;
	logic [CNT_W-1:0]            fb_rd_q;

	// table memory (circular, head_q is logical 0) and refire buffer
	otq_pkg::entry_t             table_mem_q [MAX_TIMERS];
	otq_pkg::entry_t             rd_q;
	otq_pkg::refire_t            fbuf_mem_q [MAX_TIMERS];
	otq_pkg::refire_t            fb_rdata_q;

	logic                        res_valid_q;
	logic [1:0]                  res_kind_q;
	logic [otq_pkg::ID_W-1:0]    res_id_q;
	logic                        res_arm_q;
	logic [otq_pkg::DUE_W-1:0]   res_delay_q;
	logic                        res_last_q;

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] p);
		return (p == '0) ? LAST_IDX : p - IDX_W'(1);
	endfunction

	// ---------------------------------------------------------------
	// Address arithmetic
	// ---------------------------------------------------------------
	logic [SUM_W-1:0]  tail_sum;
	logic [IDX_W-1:0]  tail_idx;
	logic [IDX_W-1:0]  walk_prev;

	always_comb begin
		tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
		if (tail_sum >= SUM_W'(MAX_TIMERS)) begin
			tail_sum = tail_sum - SUM_W'(MAX_TIMERS);
		end
		tail_idx  = tail_sum[IDX_W-1:0];
		walk_prev = idx_prev(walk_ptr_q);
	end

	// ---------------------------------------------------------------
	// Shared key comparator: {due,id} of the entry read back against
	// the operand the current step needs.
	//   head check : entry.due > new due        (strictly later head)
	//   drain      : entry.due > now            (not yet due)
	//   insertion  : entry key > new key        (entry moves up a slot)
	// ---------------------------------------------------------------
	logic [KEY_W-1:0] cmp_a;
	logic [KEY_W-1:0] cmp_b;
	logic             cmp_gt;

	always_comb begin
		case (state_q)
			ST_INS: begin
				cmp_a = {rd_q.due, rd_q.id};
				cmp_b = {new_due_q, new_id_q};
			end
			ST_E_CHK: begin
				cmp_a = {rd_q.due, {otq_pkg::ID_W{1'b0}}};
				cmp_b = {now_q, {otq_pkg::ID_W{1'b1}}};
			end
			default: begin
				cmp_a = {rd_q.due, {otq_pkg::ID_W{1'b0}}};
				cmp_b = {new_due_q, {otq_pkg::ID_W{1'b1}}};
			end
		endcase
		cmp_gt = (cmp_a > cmp_b);
	end

	// ---------------------------------------------------------------
	// Arm delay: (deadline - now) clamped at zero, then raised to min
	// ---------------------------------------------------------------
	logic [otq_pkg::DUE_W-1:0] arm_base;
	logic [otq_pkg::DUE_W:0]   arm_diff;
	logic [otq_pkg::DUE_W-1:0] arm_val;

	always_comb begin
		arm_base = (state_q == ST_E_FIN) ? rd_q.due : new_due_q;
		arm_diff = {1'b0, arm_base} - {1'b0, now_q};
		arm_val  = arm_diff[otq_pkg::DUE_W] ? '0 : arm_diff[otq_pkg::DUE_W-1:0];
		if (arm_val < otq_pkg::DUE_W'(min_delay_q)) begin
			arm_val = otq_pkg::DUE_W'(min_delay_q);
		end
	end

	// refire deadline: now + period, saturating at 2^48 - 1
	logic [otq_pkg::DUE_W:0]   refire_sum;
	logic [otq_pkg::DUE_W-1:0] refire_due;

	always_comb begin
		refire_sum = {1'b0, now_q} + (otq_pkg::DUE_W + 1)'(fb_rdata_q.period);
		refire_due = refire_sum[otq_pkg::DUE_W] ? {otq_pkg::DUE_W{1'b1}}
			: refire_sum[otq_pkg::DUE_W-1:0];
	end

	// ---------------------------------------------------------------
	// Memory port control
	// ---------------------------------------------------------------
	logic              accept;
	logic              ins_place;  // new timer lands in walk_ptr_q this cycle
	logic              drain_hit;
	logic [IDX_W-1:0]  rd_addr;
	logic              mem_we;
	otq_pkg::entry_t   mem_wdata;
	logic [IDX_W-1:0]  fb_raddr;
	logic              fb_we;
	logic [CNT_W-1:0]  fb_rd_inc;

	assign accept    = start && (state_q == ST_IDLE);
	assign ins_place = (state_q == ST_INS) && ((walk_n_q == '0) || !cmp_gt);
	assign drain_hit = (state_q == ST_E_CHK) && (count_q != '0) && !cmp_gt;
	assign fb_we     = drain_hit && (rd_q.period != '0);
	assign fb_rd_inc = fb_rd_q + CNT_W'(1);

	always_comb begin
		case (state_q)
			ST_A_HEAD, ST_R_LOAD: rd_addr = idx_prev(tail_idx);
			ST_INS:               rd_addr = idx_prev(walk_prev);
			ST_E_CHK:             rd_addr = idx_next(head_q);
			default:              rd_addr = head_q;
		endcase
		mem_we    = (state_q == ST_INS);
		mem_wdata = ins_place ? {new_due_q, new_id_q, new_per_q} : rd_q;
		fb_raddr  = (state_q == ST_INS) ? fb_rd_inc[IDX_W-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem_q[walk_ptr_q] <= mem_wdata;
		end
		rd_q <= table_mem_q[rd_addr];
		if (fb_we) begin
			fbuf_mem_q[fb_n_q[IDX_W-1:0]] <= '{id: rd_q.id, period: rd_q.period};
		end
		fb_rdata_q <= fbuf_mem_q[fb_raddr];
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			min_delay_q <= otq_pkg::MIN_ARM_RESET;
			refill_q    <= 1'b0;
			earliest_q  <= 1'b0;
			walk_ptr_q  <= '0;
			walk_n_q    <= '0;
			fb_n_q      <= '0;
			fb_rd_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			if (min_arm_delay_we) begin
				min_delay_q <= min_arm_delay;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						now_q     <= now_time;
						new_due_q <= due_time;
						new_id_q  <= timer_id;
						new_per_q <= repeat_period;
						refill_q  <= (req_type == otq_pkg::REQ_EXPIRE);
						fb_n_q    <= '0;
						fb_rd_q   <= '0;
						if (req_type == otq_pkg::REQ_EXPIRE) begin
							state_q <= ST_E_CHK;
						end else if (count_q == FULL_CNT) begin
							// refused: single word, nothing stored
							res_valid_q <= 1'b1;
							res_kind_q  <= otq_pkg::KIND_FULL;
							res_id_q    <= timer_id;
							res_arm_q   <= 1'b0;
							res_delay_q <= '0;
							res_last_q  <= 1'b1;
						end else begin
							state_q <= ST_A_HEAD;
						end
					end
				end
				ST_A_HEAD: begin
					earliest_q <= (count_q == '0) || cmp_gt;
					walk_ptr_q <= tail_idx;
					walk_n_q   <= count_q;
					state_q    <= ST_INS;
				end
				ST_INS: begin
					if (ins_place) begin
						count_q <= count_q + CNT_W'(1);
						if (!refill_q) begin
							res_valid_q <= 1'b1;
							res_kind_q  <= otq_pkg::KIND_ADD_OK;
							res_id_q    <= new_id_q;
							res_arm_q   <= earliest_q;
							res_delay_q <= earliest_q ? arm_val : '0;
							res_last_q  <= 1'b1;
							state_q     <= ST_IDLE;
						end else begin
							fb_rd_q <= fb_rd_inc;
							state_q <= (fb_rd_inc == fb_n_q) ? ST_E_RD : ST_R_LOAD;
						end
					end else begin
						// entry is later than the new timer: move it up one slot
						walk_ptr_q <= walk_prev;
						walk_n_q   <= walk_n_q - CNT_W'(1);
					end
				end
				ST_E_CHK: begin
					if (drain_hit) begin
						res_valid_q <= 1'b1;
						res_kind_q  <= otq_pkg::KIND_FIRED;
						res_id_q    <= rd_q.id;
						res_arm_q   <= 1'b0;
						res_delay_q <= '0;
						res_last_q  <= 1'b0;
						head_q      <= idx_next(head_q);
						count_q     <= count_q - CNT_W'(1);
						if (fb_we) begin
							fb_n_q <= fb_n_q + CNT_W'(1);
						end
					end else begin
						state_q <= (fb_n_q == '0) ? ST_E_RD : ST_R_LOAD;
					end
				end
				ST_R_LOAD: begin
					new_due_q  <= refire_due;
					new_id_q   <= fb_rdata_q.id;
					new_per_q  <= fb_rdata_q.period;
					walk_ptr_q <= tail_idx;
					walk_n_q   <= count_q;
					state_q    <= ST_INS;
				end
				ST_E_RD: begin
					state_q <= ST_E_FIN;
				end
				ST_E_FIN: begin
					res_valid_q <= 1'b1;
					res_kind_q  <= otq_pkg::KIND_EXP_DONE;
					res_id_q    <= '0;
					res_arm_q   <= (count_q != '0);
					res_delay_q <= (count_q != '0) ? arm_val : '0;
					res_last_q  <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result_kind  = res_kind_q;
	assign fired_id     = res_id_q;
	assign arm_valid    = res_arm_q;
	assign arm_delay    = res_delay_q;
	assign last_result  = res_last_q;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	// the table never overfills
	`OTQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= FULL_CNT)
	// an accepted request either runs or answers at once with its final word
	`OTQ_ASSERT_NEXT(a_accept_progress, accept, busy || (result_valid && last_result))
	// only the final word of a request frees the block
	`OTQ_ASSERT_NOW(a_last_frees, result_valid, last_result == !busy)

endmodule
